>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/blcu_pkg.sv
// ----------------------------------------------------------------------------
// blcu_pkg
// Types and constants of the byte list with compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blcu_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_GET    = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]        command;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
    } t_out_beat;

    // Broadcast from the control to every cell of the row.
    typedef struct packed {
        logic              push_en;
        logic              set_en;
        logic              rem_en;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> sv/blcu_cell.sv
// ----------------------------------------------------------------------------
// blcu_cell
// One list slot: holds a byte, takes pushes and sets aimed at its position,
// and on remove takes its upper neighbor's byte or clears itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blcu_cell #(
    parameter int CELL_POS = 0
) (
    input  wire                              i_clk,
    input  wire  blcu_pkg::t_cell_ctrl       i_ctrl,
    input  wire  [blcu_pkg::DATA_W-1:0]      i_next_data,
    output logic [blcu_pkg::DATA_W-1:0]      o_data,
    output logic [blcu_pkg::DATA_W-1:0]      o_rd_data
);

    localparam logic [blcu_pkg::IDX_W-1:0] MY_IDX  = blcu_pkg::IDX_W'(CELL_POS);
    localparam logic [blcu_pkg::CNT_W-1:0] MY_POS  = blcu_pkg::CNT_W'(CELL_POS);
    localparam logic [blcu_pkg::CNT_W-1:0] MY_LAST = blcu_pkg::CNT_W'(CELL_POS + 1);

    logic [blcu_pkg::DATA_W-1:0] r_data;
    logic [blcu_pkg::DATA_W-1:0] n_data;
    logic                        is_idx;
    logic                        is_tail;
    logic                        is_last;
    logic                        is_above;

    assign is_idx   = (i_ctrl.idx == MY_IDX);
    assign is_tail  = (i_ctrl.count == MY_POS);
    assign is_last  = (i_ctrl.count == MY_LAST);
    assign is_above = (MY_IDX >= i_ctrl.idx);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.push_en && is_tail) begin
            n_data = i_ctrl.value;
        end else if (i_ctrl.set_en && is_idx) begin
            n_data = i_ctrl.value;
        end else if (i_ctrl.rem_en && is_last) begin
            n_data = '0;
        end else if (i_ctrl.rem_en && is_above) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = is_idx ? r_data : '0;

endmodule

`default_nettype wire

>>> sv/byte_list_with_compaction_unit.sv
// ----------------------------------------------------------------------------
// byte_list_with_compaction_unit
// Ordered byte list with push, set, get and remove-with-compaction.
// ----------------------------------------------------------------------------
// Takes one command beat per cycle; its result beat appears in the output
// register on the next cycle and the input stalls only while that register
// is full and stalled downstream. Storage is a row of 64 byte cells: a
// remove moves every later entry down one place at once through
// the cell-to-cell links, and get selects the indexed cell directly.
// Set, get or remove at or beyond the count and a push onto a full list
// return ok=0. No clearing pass after reset: the count starts at zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module byte_list_with_compaction_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire blcu_pkg::t_in_beat i_in_beat,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output blcu_pkg::t_out_beat   o_out_beat
);

    localparam int DEPTH = blcu_pkg::DEPTH;
    localparam logic [blcu_pkg::CNT_W-1:0] FULL = blcu_pkg::CNT_W'(DEPTH);

    logic [blcu_pkg::CNT_W-1:0]  r_count;
    logic [blcu_pkg::CNT_W-1:0]  n_count;
    logic                        r_out_valid;
    blcu_pkg::t_out_beat         r_out_beat;
    blcu_pkg::t_out_beat         n_out_beat;
    blcu_pkg::t_cell_ctrl        ctrl;

    logic                        accept;
    logic                        in_range;
    logic                        cmd_ok;
    logic [blcu_pkg::DATA_W-1:0] rd_any;

    logic [blcu_pkg::DATA_W-1:0] cell_data [DEPTH+1];
    logic [blcu_pkg::DATA_W-1:0] cell_rd   [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_in_beat.index} < r_count);

    always_comb begin
        case (i_in_beat.command)
            blcu_pkg::CMD_PUSH:   cmd_ok = (r_count != FULL);
            blcu_pkg::CMD_SET:    cmd_ok = in_range;
            blcu_pkg::CMD_GET:    cmd_ok = in_range;
            blcu_pkg::CMD_REMOVE: cmd_ok = in_range;
            default:              cmd_ok = 1'b0;
        endcase
    end

    always_comb begin
        ctrl.push_en = accept && cmd_ok && (i_in_beat.command == blcu_pkg::CMD_PUSH);
        ctrl.set_en  = accept && cmd_ok && (i_in_beat.command == blcu_pkg::CMD_SET);
        ctrl.rem_en  = accept && cmd_ok && (i_in_beat.command == blcu_pkg::CMD_REMOVE);
        ctrl.idx     = i_in_beat.index;
        ctrl.count   = r_count;
        ctrl.value   = i_in_beat.value;
    end

    assign cell_data[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        blcu_cell #(
            .CELL_POS (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_next_data (cell_data[g+1]),
            .o_data      (cell_data[g]),
            .o_rd_data   (cell_rd[g])
        );
    end

    always_comb begin
        rd_any = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_any = rd_any | cell_rd[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (ctrl.push_en) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.rem_en) begin
            n_count = r_count - 1'b1;
        end
        n_out_beat.ok         = cmd_ok;
        n_out_beat.read_value = (cmd_ok && (i_in_beat.command == blcu_pkg::CMD_GET))
                                ? rd_any : '0;
        n_out_beat.count      = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= FULL, "count beyond depth")
    `ASSERT_CLK(a_out_count, i_clk, i_rst_n, r_out_valid |-> (r_out_beat.count == r_count), "result count differs from list count")
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, (r_out_valid && !r_out_beat.ok) |-> (r_out_beat.read_value == '0), "failed command returned data")
    `ASSERT_CLK(a_count_hold, i_clk, i_rst_n, !accept |=> (r_count == $past(r_count)), "count moved without a command")
    `ASSERT_CLK(a_push_inc, i_clk, i_rst_n, ctrl.push_en |=> (r_count == $past(r_count) + 1'b1), "push did not grow the list")

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_list_with_compaction_unit. A driver sends
// command beats from a backlog; each accepted beat updates a shadow byte
// list to work out the expected result beat. A monitor compares every
// accepted result beat field by field with the oldest expected one. The run
// starts with directed corner cases, then random phases that cover every
// mix of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import blcu_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int BIAS_STRETCH  = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_beat   in_beat   = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_beat  o_out_beat;

    t_in_beat   cmd_backlog[$];
    t_out_beat  result_due[$];

    logic [DATA_W-1:0] list_mem [DEPTH] = '{default: '0};
    logic [CNT_W-1:0]  list_len = '0;
    int                shadow_len = 0;

    t_idle_mode idle_mode = IDLE_NONE;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         in_taken = 1'b0;
    bit         mismatch = 1'b0;
    int         cycle_count = 0;

    byte_list_with_compaction_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always_comb begin
        send_idle_pct  = (idle_mode == IDLE_SEND) ? 47 : (idle_mode == IDLE_BOTH) ? 37 : 0;
        recv_stall_pct = (idle_mode == IDLE_RECV) ? 47 : (idle_mode == IDLE_BOTH) ? 37 : 0;
    end

    task automatic apply_list_cmd(input t_in_beat c, output t_out_beat r);
        r = '0;
        case (t_cmd'(c.command))
            CMD_PUSH: begin
                if (list_len < DEPTH) begin
                    list_mem[list_len[IDX_W-1:0]] = c.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_SET: begin
                if (c.index < list_len) begin
                    list_mem[c.index] = c.value;
                    r.ok = 1'b1;
                end
            end
            CMD_GET: begin
                if (c.index < list_len) begin
                    r.read_value = list_mem[c.index];
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (c.index < list_len) begin
                    for (int j = c.index; j < list_len - 1; j++) begin
                        list_mem[j] = list_mem[j+1];
                    end
                    list_mem[list_len - 1] = '0;
                    list_len--;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.count = list_len;
    endtask

    always @(negedge clk) begin : drive_inputs
        logic     next_valid;
        t_in_beat next_beat;
        next_valid = in_valid;
        next_beat  = in_beat;
        if (!in_valid || in_taken) begin
            next_valid = 1'b0;
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_beat  = cmd_backlog.pop_front();
                next_valid = 1'b1;
            end
        end
        in_valid  <= next_valid;
        in_beat   <= next_beat;
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin : watch_ports
        t_out_beat want;
        t_out_beat got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("byte_list_with_compaction_unit verification failed");
            $finish;
        end else begin
            in_taken = rst_n && in_valid && !o_in_stall;
            if (in_taken) begin
                apply_list_cmd(in_beat, want);
                result_due.push_back(want);
            end
            if (rst_n && o_out_valid && !out_stall) begin
                got = o_out_beat;
                if (result_due.size() == 0) begin
                    $error("result beat with nothing expected: ok=%0d read_value=%0d count=%0d",
                           got.ok, got.read_value, got.count);
                    mismatch = 1'b1;
                end else begin
                    want = result_due.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        mismatch = 1'b1;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, got.read_value);
                        mismatch = 1'b1;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatch = 1'b1;
                    end
                end
            end
        end
    end

    task automatic add_cmd(input t_cmd op, input int idx, input int val);
        t_in_beat b;
        b.command = op;
        b.index   = idx[IDX_W-1:0];
        b.value   = val[DATA_W-1:0];
        cmd_backlog.push_back(b);
        if (op == CMD_PUSH && shadow_len < DEPTH) begin
            shadow_len++;
        end else if (op == CMD_REMOVE && idx < shadow_len) begin
            shadow_len--;
        end
    endtask

    task automatic add_random_cmd(input int push_pct);
        int   pick;
        int   idx;
        t_cmd op;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            op = CMD_PUSH;
        end else begin
            case (pick % 3)
                0:       op = CMD_SET;
                1:       op = CMD_GET;
                default: op = CMD_REMOVE;
            endcase
        end
        if (shadow_len > 0 && $urandom_range(0, 9) != 0) begin
            idx = $urandom_range(0, shadow_len - 1);
        end else begin
            idx = $urandom_range(0, DEPTH - 1);
        end
        add_cmd(op, idx, $urandom_range(0, 255));
    endtask

    // full list: pushes refused, top slot reachable, then compaction from both ends
    task automatic add_fill_sequence();
        while (shadow_len < DEPTH) begin
            add_cmd(CMD_PUSH, $urandom_range(0, DEPTH - 1), $urandom_range(0, 255));
        end
        add_cmd(CMD_PUSH, 0, 8'hFF);
        add_cmd(CMD_PUSH, DEPTH - 1, 8'h00);
        add_cmd(CMD_GET, DEPTH - 1, 0);
        add_cmd(CMD_SET, DEPTH - 1, 8'hFF);
        add_cmd(CMD_GET, DEPTH - 1, 0);
        add_cmd(CMD_REMOVE, DEPTH - 1, 0);
        add_cmd(CMD_GET, DEPTH - 1, 0);
        add_cmd(CMD_REMOVE, 0, 0);
        add_cmd(CMD_GET, 0, 0);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (cmd_backlog.size() != 0 || in_valid || result_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin : run_test
        int push_pct;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_mode = IDLE_NONE;
        add_cmd(CMD_GET, 0, 0);
        add_cmd(CMD_SET, 0, 8'h11);
        add_cmd(CMD_REMOVE, 0, 0);
        add_cmd(CMD_PUSH, DEPTH - 1, 8'h00);
        add_cmd(CMD_PUSH, 0, 8'hFF);
        add_cmd(CMD_PUSH, 42, 8'h80);
        add_cmd(CMD_GET, 0, 0);
        add_cmd(CMD_GET, 1, 0);
        add_cmd(CMD_GET, 2, 0);
        add_cmd(CMD_GET, 3, 0);
        add_cmd(CMD_GET, DEPTH - 1, 8'hFF);
        add_cmd(CMD_SET, 1, 8'h55);
        add_cmd(CMD_SET, 3, 8'hAA);
        add_cmd(CMD_GET, 1, 0);
        add_cmd(CMD_REMOVE, 0, 0);
        add_cmd(CMD_GET, 0, 0);
        add_cmd(CMD_REMOVE, 1, 0);
        add_cmd(CMD_GET, 1, 0);
        add_cmd(CMD_GET, 0, 0);
        add_cmd(CMD_REMOVE, 0, 0);
        add_cmd(CMD_GET, 0, 0);
        add_cmd(CMD_PUSH, 21, 8'hAA);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            idle_mode = t_idle_mode'(phase % 4);
            push_pct  = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % BIAS_STRETCH == 0) begin
                    push_pct = $urandom_range(15, 75);
                end
                add_random_cmd(push_pct);
            end
            if (phase == 1 || phase == 6) begin
                add_fill_sequence();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (!mismatch && result_due.size() == 0) begin
            $display("byte_list_with_compaction_unit verification clean");
        end else begin
            $display("byte_list_with_compaction_unit verification failed");
        end
        $finish;
    end

endmodule
